[rtl/rob_pkg.sv]
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types and action codes of the reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;

   // action codes
   localparam logic [2:0] ACT_ALLOC       = 3'd0;
   localparam logic [2:0] ACT_ISSUE       = 3'd1;
   localparam logic [2:0] ACT_FINISH      = 3'd2;
   localparam logic [2:0] ACT_COMMIT      = 3'd3;
   localparam logic [2:0] ACT_FLUSH       = 3'd4;
   localparam logic [2:0] ACT_ROOM        = 3'd5;
   localparam logic [2:0] ACT_LIST_ISSUE  = 3'd6;
   localparam logic [2:0] ACT_LIST_COMMIT = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] inst_tag;
      logic [5:0]  entry_index;
      logic [3:0]  group_count;
      logic        read_entry;
   } req_type;

   typedef struct packed {
      logic        has_entry;
      logic [5:0]  out_index;
      logic [15:0] out_tag;
      logic [6:0]  free_entries;
      logic        room_ok;
      logic        error_code;
      logic        last_result;
   } rsp_type;

   // command handed from the front queue to the back engine
   typedef struct packed {
      req_type    req;
      logic       walk;
      logic [3:0] limit;
   } cmd_type;

endpackage

[rtl/rob_front.sv]
// ----------------------------------------------------------------------------
// rob_front
// Request queue: accepts requests, clamps the group count and marks walks.
// ----------------------------------------------------------------------------
module rob_front #(
   parameter int GROUP_MAX = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rob_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_pop,
   output rob_pkg::cmd_type q_data
);

   rob_pkg::cmd_type slot_ff [2];
   rob_pkg::cmd_type cmd_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   // classify the incoming request
   always_comb begin
      cmd_in.req   = req_data;
      cmd_in.walk  = (req_data.action == rob_pkg::ACT_COMMIT) ||
                     (req_data.action == rob_pkg::ACT_LIST_ISSUE) ||
                     (req_data.action == rob_pkg::ACT_LIST_COMMIT);
      if (32'(req_data.group_count) > GROUP_MAX) begin
         cmd_in.limit = 4'(GROUP_MAX);
      end else begin
         cmd_in.limit = req_data.group_count;
      end
   end

   assign req_full = (cnt_ff == 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = slot_ff[rd_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   // pointer and count update
   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = 2'(cnt_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= cmd_in;
      end
   end

endmodule

[rtl/rob_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// rob_rsp_fifo
// Two-entry result queue between the back engine and the result port.
// ----------------------------------------------------------------------------
module rob_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  rob_pkg::rsp_type push_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rob_pkg::rsp_type rsp_data
);

   rob_pkg::rsp_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = rsp_pop && !rsp_empty;

   // pointer and count update
   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = 2'(cnt_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/rob_core.sv]
// ----------------------------------------------------------------------------
// rob_core
// Back engine: buffer state, tag memory, head walks and result emission.
// ----------------------------------------------------------------------------
module rob_core #(
   parameter int DEPTH     = 64,
   parameter int GROUP_MAX = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  rob_pkg::cmd_type q_data,
   output logic             rsp_push,
   input  logic             rsp_full,
   output rob_pkg::rsp_type rsp_out
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int HW = $clog2(GROUP_MAX + 1);
   localparam int SW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in, tail_ff, tail_in, ptr_ff, ptr_in;
   logic [OW-1:0]    occ_ff, occ_in, step_ff, step_in;
   logic [DEPTH-1:0] valid_ff, valid_in, issued_ff, issued_in, fin_ff, fin_in;
   logic [HW-1:0]    nh_ff, nh_in, emit_ff, emit_in;
   logic             has_ff, has_in, err_ff, err_in;
   logic             pend_ff, pend_in;
   logic [SW-1:0]    pend_slot_ff, pend_slot_in;
   rob_pkg::cmd_type cmd_ff, cmd_in;

   logic [AW-1:0]    hit_idx_ff [GROUP_MAX];
   logic [15:0]      hit_tag_ff [GROUP_MAX];
   logic             hit_wr_en, tag_wr_en;
   logic [SW-1:0]    hit_wr_slot, tag_wr_slot;
   logic [AW-1:0]    hit_wr_idx;
   logic [15:0]      tag_direct, tag_wr_data;

   logic [15:0]      tag_mem [DEPTH];
   logic             mem_wr_en, mem_rd_en;
   logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [15:0]      mem_rd_data_ff;

   logic             eidx_ok, lim_hit, last;
   logic [AW-1:0]    eidx_a, cur;
   logic [OW-1:0]    free_cnt;

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      if (32'(i) == DEPTH - 1) begin
         return '0;
      end
      return AW'(i + 1'b1);
   endfunction

   assign eidx_ok  = 32'(q_data.req.entry_index) < DEPTH;
   assign eidx_a   = AW'(q_data.req.entry_index);
   assign lim_hit  = nh_ff >= HW'(cmd_ff.limit);
   assign cur      = (cmd_ff.req.action == rob_pkg::ACT_COMMIT) ? head_ff : ptr_ff;
   assign free_cnt = OW'(DEPTH) - occ_ff;
   assign last     = has_ff ? (HW'(emit_ff + 1'b1) == nh_ff) : 1'b1;

   // result word of the current emit slot
   always_comb begin
      rsp_out.has_entry    = has_ff;
      rsp_out.out_index    = has_ff ? 6'(hit_idx_ff[emit_ff[SW-1:0]]) : 6'd0;
      rsp_out.out_tag      = has_ff ? hit_tag_ff[emit_ff[SW-1:0]] : 16'd0;
      rsp_out.free_entries = 7'(free_cnt);
      rsp_out.room_ok      = 32'(free_cnt) >= 32'(cmd_ff.req.group_count);
      rsp_out.error_code   = err_ff;
      rsp_out.last_result  = last;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      occ_in       = occ_ff;
      step_in      = step_ff;
      valid_in     = valid_ff;
      issued_in    = issued_ff;
      fin_in       = fin_ff;
      nh_in        = nh_ff;
      emit_in      = emit_ff;
      has_in       = has_ff;
      err_in       = err_ff;
      cmd_in       = cmd_ff;
      pend_in      = 1'b0;
      pend_slot_in = pend_slot_ff;
      q_pop        = 1'b0;
      rsp_push     = 1'b0;
      hit_wr_en    = 1'b0;
      hit_wr_slot  = nh_ff[SW-1:0];
      hit_wr_idx   = cur;
      tag_wr_en    = pend_ff;
      tag_wr_slot  = pend_slot_ff;
      tag_direct   = q_data.req.inst_tag;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = tail_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = cur;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               nh_in    = '0;
               emit_in  = '0;
               has_in   = 1'b0;
               err_in   = 1'b0;
               ptr_in   = head_ff;
               step_in  = '0;
               state_in = ST_EMIT;
               case (q_data.req.action)
                  rob_pkg::ACT_ALLOC: begin
                     if (32'(occ_ff) >= DEPTH) begin
                        err_in = 1'b1;
                     end else begin
                        mem_wr_en         = 1'b1;
                        valid_in[tail_ff]  = 1'b1;
                        issued_in[tail_ff] = 1'b0;
                        fin_in[tail_ff]    = 1'b0;
                        tail_in           = next_idx(tail_ff);
                        occ_in            = OW'(occ_ff + 1'b1);
                        hit_wr_en         = 1'b1;
                        hit_wr_slot       = '0;
                        hit_wr_idx        = tail_ff;
                        tag_wr_en         = 1'b1;
                        tag_wr_slot       = '0;
                        nh_in             = HW'(1);
                        has_in            = 1'b1;
                     end
                  end
                  rob_pkg::ACT_ISSUE: begin
                     if (eidx_ok) begin
                        issued_in[eidx_a] = 1'b1;
                     end
                  end
                  rob_pkg::ACT_FINISH: begin
                     if (eidx_ok) begin
                        fin_in[eidx_a] = 1'b1;
                     end
                  end
                  rob_pkg::ACT_FLUSH: begin
                     valid_in  = '0;
                     issued_in = '0;
                     fin_in    = '0;
                     head_in   = '0;
                     tail_in   = '0;
                     occ_in    = '0;
                  end
                  rob_pkg::ACT_ROOM: begin
                     if (q_data.req.read_entry && eidx_ok) begin
                        hit_wr_en    = 1'b1;
                        hit_wr_slot  = '0;
                        hit_wr_idx   = eidx_a;
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = eidx_a;
                        pend_in      = 1'b1;
                        pend_slot_in = '0;
                        nh_in        = HW'(1);
                        has_in       = 1'b1;
                        state_in     = ST_DRAIN;
                     end
                  end
                  default: begin
                     state_in = ST_WALK;
                  end
               endcase
            end
         end
         ST_WALK: begin
            case (cmd_ff.req.action)
               rob_pkg::ACT_COMMIT: begin
                  if (lim_hit || occ_ff == '0 ||
                      !(valid_ff[head_ff] && issued_ff[head_ff] && fin_ff[head_ff])) begin
                     state_in = ST_DRAIN;
                  end else begin
                     valid_in[head_ff]  = 1'b0;
                     issued_in[head_ff] = 1'b0;
                     fin_in[head_ff]    = 1'b0;
                     head_in           = next_idx(head_ff);
                     occ_in            = OW'(occ_ff - 1'b1);
                     hit_wr_en         = 1'b1;
                     mem_rd_en         = 1'b1;
                     pend_in           = 1'b1;
                     pend_slot_in      = nh_ff[SW-1:0];
                     nh_in             = HW'(nh_ff + 1'b1);
                  end
               end
               rob_pkg::ACT_LIST_ISSUE: begin
                  if (lim_hit || step_ff == occ_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     if (valid_ff[ptr_ff] && !issued_ff[ptr_ff]) begin
                        hit_wr_en    = 1'b1;
                        mem_rd_en    = 1'b1;
                        pend_in      = 1'b1;
                        pend_slot_in = nh_ff[SW-1:0];
                        nh_in        = HW'(nh_ff + 1'b1);
                     end
                     ptr_in  = next_idx(ptr_ff);
                     step_in = OW'(step_ff + 1'b1);
                  end
               end
               default: begin
                  if (lim_hit || step_ff == occ_ff || !fin_ff[ptr_ff]) begin
                     state_in = ST_DRAIN;
                  end else begin
                     hit_wr_en    = 1'b1;
                     mem_rd_en    = 1'b1;
                     pend_in      = 1'b1;
                     pend_slot_in = nh_ff[SW-1:0];
                     nh_in        = HW'(nh_ff + 1'b1);
                     ptr_in       = next_idx(ptr_ff);
                     step_in      = OW'(step_ff + 1'b1);
                  end
               end
            endcase
            if (state_in == ST_DRAIN) begin
               has_in = (nh_ff != '0);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         default: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (last) begin
                  state_in = ST_IDLE;
                  emit_in  = '0;
               end else begin
                  emit_in = HW'(emit_ff + 1'b1);
               end
            end
         end
      endcase
      tag_wr_data = pend_ff ? mem_rd_data_ff : tag_direct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         occ_ff    <= '0;
         valid_ff  <= '0;
         issued_ff <= '0;
         fin_ff    <= '0;
         nh_ff     <= '0;
         emit_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         occ_ff    <= occ_in;
         valid_ff  <= valid_in;
         issued_ff <= issued_in;
         fin_ff    <= fin_in;
         nh_ff     <= nh_in;
         emit_ff   <= emit_in;
         pend_ff   <= pend_in;
      end
   end

   // command and walk payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      ptr_ff       <= ptr_in;
      step_ff      <= step_in;
      has_ff       <= has_in;
      err_ff       <= err_in;
      pend_slot_ff <= pend_slot_in;
      if (hit_wr_en) begin
         hit_idx_ff[hit_wr_slot] <= hit_wr_idx;
      end
      if (tag_wr_en) begin
         hit_tag_ff[tag_wr_slot] <= tag_wr_data;
      end
   end

   // tag memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tag_mem[mem_wr_addr] <= q_data.req.inst_tag;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= tag_mem[mem_rd_addr];
      end
   end

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= DEPTH)
      else $error("occupancy beyond depth");
   a_push_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> state_ff == ST_EMIT)
      else $error("result transfer outside emit");
   a_walk_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> nh_ff <= HW'(cmd_ff.limit))
      else $error("walk collected too many entries");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE)
      else $error("command taken while busy");

endmodule

[rtl/reorder_buffer.sv]
// ----------------------------------------------------------------------------
// reorder_buffer
// Circular reorder buffer of instruction tags with valid, issued and
// finished marks per entry.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue interface: a transfer happens when
//   req_push is high and req_full low. Results leave through a queue
//   interface: rsp_data holds the oldest result while rsp_empty is low, and
//   rsp_pop takes it. Each request gives one or more results; the final one
//   carries last_result.
//   A two-entry request queue feeds the back engine, which handles one
//   request at a time. Allocate, issue, finish and flush go from idle
//   straight to the emit state; a tag read passes through a drain state
//   first. Commit and the two list walks step one buffer entry per cycle
//   from the head in the walk state, then drain and emit one result per
//   entry found, or a single empty one (list issuable may visit every
//   occupied entry). The engine goes back to idle after each request,
//   before it takes the next one.
//   Reset empties the buffer, both queues and all marks; the tag memory is
//   left as it is. When the receiver stalls, the two-entry result queue
//   fills, the engine waits, and then the request queue backs up to full.
// ----------------------------------------------------------------------------
module reorder_buffer #(
   parameter int DEPTH     = 64,
   parameter int GROUP_MAX = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rob_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rob_pkg::rsp_type rsp_data
);

   rob_pkg::cmd_type q_data;
   rob_pkg::rsp_type core_rsp;
   logic             q_valid, q_pop, core_push, core_full;

   rob_front #(.GROUP_MAX(GROUP_MAX)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_data   (q_data)
   );

   rob_core #(.DEPTH(DEPTH), .GROUP_MAX(GROUP_MAX)) u_core (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_data   (q_data),
      .rsp_push (core_push),
      .rsp_full (core_full),
      .rsp_out  (core_rsp)
   );

   rob_rsp_fifo u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (core_push),
      .full      (core_full),
      .push_data (core_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb_reorder_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reorder_buffer
// Self-checking bench for the reorder buffer. Requests are pushed through the
// request queue with random gaps, and the bench tracks the ring, its marks and
// pointers to predict every result. Each popped result is compared field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_reorder_buffer;

   localparam int RING     = 64;
   localparam int WALK_MAX = 8;

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   rob_pkg::req_type req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   rob_pkg::rsp_type rsp_data;

   reorder_buffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // mirror of the ring
   logic [15:0] ring_tag [RING];
   bit          ring_valid [RING];
   bit          ring_issued [RING];
   bit          ring_finished [RING];
   bit          tag_written [RING];
   int unsigned head_idx;
   int unsigned tail_idx;
   int unsigned occ_count;

   rob_pkg::rsp_type pending_rsps[$];
   bit               failed;
   bit               hold_rsp;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic rob_pkg::rsp_type make_rsp(bit has, int unsigned idx,
                                                 logic [15:0] tg, logic [3:0] cnt,
                                                 bit err);
      rob_pkg::rsp_type r;
      r.has_entry    = has;
      r.out_index    = has ? idx[5:0] : 6'd0;
      r.out_tag      = has ? tg : 16'd0;
      r.free_entries = 7'(RING - occ_count);
      r.room_ok      = (RING - occ_count) >= cnt;
      r.error_code   = err;
      r.last_result  = 1'b0;
      return r;
   endfunction

   // work out the results of one accepted request and update the mirror
   function automatic void predict_results(rob_pkg::req_type q);
      rob_pkg::rsp_type batch[$];
      rob_pkg::rsp_type t;
      int unsigned      hits[$];
      int unsigned      lim;
      int unsigned      idx;
      lim = (q.group_count > WALK_MAX) ? WALK_MAX : q.group_count;
      case (q.action)
         rob_pkg::ACT_ALLOC: begin
            if (occ_count >= RING) begin
               batch.push_back(make_rsp(0, 0, 0, q.group_count, 1));
            end else begin
               idx = tail_idx;
               ring_tag[idx]      = q.inst_tag;
               tag_written[idx]   = 1;
               ring_valid[idx]    = 1;
               ring_issued[idx]   = 0;
               ring_finished[idx] = 0;
               tail_idx  = (tail_idx + 1) % RING;
               occ_count++;
               batch.push_back(make_rsp(1, idx, q.inst_tag, q.group_count, 0));
            end
         end
         rob_pkg::ACT_ISSUE, rob_pkg::ACT_FINISH: begin
            if (q.action == rob_pkg::ACT_ISSUE) ring_issued[q.entry_index] = 1;
            else ring_finished[q.entry_index] = 1;
            batch.push_back(make_rsp(0, 0, 0, q.group_count, 0));
         end
         rob_pkg::ACT_COMMIT: begin
            for (int i = 0; i < lim && occ_count > 0; i++) begin
               idx = head_idx;
               if (!(ring_valid[idx] && ring_issued[idx] && ring_finished[idx])) break;
               ring_valid[idx]    = 0;
               ring_issued[idx]   = 0;
               ring_finished[idx] = 0;
               hits.push_back(idx);
               head_idx = (head_idx + 1) % RING;
               occ_count--;
            end
         end
         rob_pkg::ACT_FLUSH: begin
            for (int i = 0; i < RING; i++) begin
               ring_valid[i]    = 0;
               ring_issued[i]   = 0;
               ring_finished[i] = 0;
            end
            head_idx  = 0;
            tail_idx  = 0;
            occ_count = 0;
            batch.push_back(make_rsp(0, 0, 0, q.group_count, 0));
         end
         rob_pkg::ACT_ROOM: begin
            if (q.read_entry)
               batch.push_back(make_rsp(1, q.entry_index, ring_tag[q.entry_index],
                                        q.group_count, 0));
            else
               batch.push_back(make_rsp(0, 0, 0, q.group_count, 0));
         end
         rob_pkg::ACT_LIST_ISSUE: begin
            idx = head_idx;
            for (int i = 0; i < occ_count && hits.size() < lim; i++) begin
               if (ring_valid[idx] && !ring_issued[idx]) hits.push_back(idx);
               idx = (idx + 1) % RING;
            end
         end
         default: begin
            idx = head_idx;
            for (int i = 0; i < occ_count && hits.size() < lim; i++) begin
               if (!ring_finished[idx]) break;
               hits.push_back(idx);
               idx = (idx + 1) % RING;
            end
         end
      endcase
      if (q.action inside {rob_pkg::ACT_COMMIT, rob_pkg::ACT_LIST_ISSUE,
                           rob_pkg::ACT_LIST_COMMIT}) begin
         if (hits.size() == 0)
            batch.push_back(make_rsp(0, 0, 0, q.group_count, 0));
         foreach (hits[k])
            batch.push_back(make_rsp(1, hits[k], ring_tag[hits[k]], q.group_count, 0));
      end
      t = batch.pop_back();
      t.last_result = 1'b1;
      batch.push_back(t);
      foreach (batch[k]) pending_rsps.push_back(batch[k]);
   endfunction

   // send one request; called at a falling edge, returns at a falling edge
   task automatic send_req(rob_pkg::req_type q);
      req_push <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_full);
      predict_results(q);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic send_one(logic [2:0] act, logic [15:0] tg, logic [5:0] idx,
                           logic [3:0] cnt, logic rd);
      rob_pkg::req_type q;
      q.action      = act;
      q.inst_tag    = tg;
      q.entry_index = idx;
      q.group_count = cnt;
      q.read_entry  = rd;
      send_req(q);
      sender_gap();
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // a random request, mostly aimed at occupied entries
   function automatic rob_pkg::req_type random_req();
      rob_pkg::req_type q;
      int unsigned      w;
      int unsigned      picks[$];
      q.inst_tag    = 16'($urandom);
      q.group_count = 4'($urandom);
      q.read_entry  = 1'($urandom);
      q.entry_index = 6'($urandom);
      if (occ_count > 0 && $urandom_range(0, 9) < 8)
         q.entry_index = 6'((head_idx + $urandom_range(0, occ_count - 1)) % RING);
      w = $urandom_range(0, 99);
      if (w < 30) q.action = rob_pkg::ACT_ALLOC;
      else if (w < 45) q.action = rob_pkg::ACT_ISSUE;
      else if (w < 60) q.action = rob_pkg::ACT_FINISH;
      else if (w < 72) q.action = rob_pkg::ACT_COMMIT;
      else if (w < 78) q.action = rob_pkg::ACT_LIST_ISSUE;
      else if (w < 84) q.action = rob_pkg::ACT_LIST_COMMIT;
      else if (w < 97) q.action = rob_pkg::ACT_ROOM;
      else q.action = rob_pkg::ACT_FLUSH;
      // only read entries that hold a tag
      if (q.action == rob_pkg::ACT_ROOM && q.read_entry &&
          !tag_written[q.entry_index]) begin
         foreach (tag_written[k]) if (tag_written[k]) picks.push_back(k);
         if (picks.size() == 0) q.read_entry = 1'b0;
         else q.entry_index = 6'(picks[$urandom_range(0, picks.size() - 1)]);
      end
      return q;
   endfunction

   task automatic test_directed();
      send_one(rob_pkg::ACT_LIST_ISSUE, 16'h0, 6'd0, 4'd8, 1'b0);
      send_one(rob_pkg::ACT_COMMIT, 16'h0, 6'd0, 4'd8, 1'b0);
      send_one(rob_pkg::ACT_ALLOC, 16'h0000, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_ALLOC, 16'hFFFF, 6'd63, 4'd15, 1'b1);
      send_one(rob_pkg::ACT_ALLOC, 16'hA5A5, 6'd0, 4'd8, 1'b0);
      send_one(rob_pkg::ACT_ROOM, 16'h0, 6'd1, 4'd15, 1'b1);
      send_one(rob_pkg::ACT_ROOM, 16'h0, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_LIST_ISSUE, 16'h0, 6'd0, 4'd15, 1'b0);
      send_one(rob_pkg::ACT_ISSUE, 16'h0, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_ISSUE, 16'h0, 6'd1, 4'd0, 1'b0);
      // marks on a free entry
      send_one(rob_pkg::ACT_FINISH, 16'h0, 6'd63, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_FINISH, 16'h0, 6'd1, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_LIST_COMMIT, 16'h0, 6'd0, 4'd8, 1'b0);
      send_one(rob_pkg::ACT_FINISH, 16'h0, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_LIST_COMMIT, 16'h0, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_LIST_COMMIT, 16'h0, 6'd0, 4'd8, 1'b0);
      send_one(rob_pkg::ACT_COMMIT, 16'h0, 6'd0, 4'd0, 1'b0);
      send_one(rob_pkg::ACT_COMMIT, 16'h0, 6'd0, 4'd12, 1'b0);
      send_one(rob_pkg::ACT_FLUSH, 16'h0, 6'd0, 4'd3, 1'b0);
      send_one(rob_pkg::ACT_ROOM, 16'h0, 6'd2, 4'd8, 1'b1);
      wait_idle();
   endtask

   // fill the ring, refuse two more, then empty it again
   task automatic test_full();
      for (int i = 0; i < RING + 2; i++)
         send_one(rob_pkg::ACT_ALLOC, 16'($urandom), 6'($urandom), 4'($urandom), 1'b0);
      send_one(rob_pkg::ACT_LIST_ISSUE, 16'h0, 6'd0, 4'd9, 1'b0);
      send_one(rob_pkg::ACT_ROOM, 16'h0, 6'd0, 4'd1, 1'b0);
      send_one(rob_pkg::ACT_FLUSH, 16'h0, 6'd0, 4'd0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random();
      repeat (90) begin
         send_req(random_req());
         sender_gap();
      end
      wait_idle();
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      repeat (30) send_req(random_req());
      wait_idle();
   endtask

   // receiver: random pops, plus the long hold-off on request
   initial begin
      int unsigned n;
      rsp_pop = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
         if ($urandom_range(0, 2) == 0) n = 0;
         if (n > 0) begin
            rsp_pop <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(negedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      rob_pkg::rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            failed = 1'b1;
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_data.has_entry !== e.has_entry) begin
               $error("has_entry: expected %0d actual %0d", e.has_entry, rsp_data.has_entry);
               failed = 1'b1;
            end
            if (rsp_data.out_index !== e.out_index) begin
               $error("out_index: expected %0d actual %0d", e.out_index, rsp_data.out_index);
               failed = 1'b1;
            end
            if (rsp_data.out_tag !== e.out_tag) begin
               $error("out_tag: expected %h actual %h", e.out_tag, rsp_data.out_tag);
               failed = 1'b1;
            end
            if (rsp_data.free_entries !== e.free_entries) begin
               $error("free_entries: expected %0d actual %0d", e.free_entries,
                      rsp_data.free_entries);
               failed = 1'b1;
            end
            if (rsp_data.room_ok !== e.room_ok) begin
               $error("room_ok: expected %0d actual %0d", e.room_ok, rsp_data.room_ok);
               failed = 1'b1;
            end
            if (rsp_data.error_code !== e.error_code) begin
               $error("error_code: expected %0d actual %0d", e.error_code,
                      rsp_data.error_code);
               failed = 1'b1;
            end
            if (rsp_data.last_result !== e.last_result) begin
               $error("last_result: expected %0d actual %0d", e.last_result,
                      rsp_data.last_result);
               failed = 1'b1;
            end
         end
      end
   end

   // test sequence
   initial begin
      failed    = 1'b0;
      hold_rsp  = 1'b0;
      head_idx  = 0;
      tail_idx  = 0;
      occ_count = 0;
      for (int i = 0; i < RING; i++) begin
         ring_tag[i]      = '0;
         ring_valid[i]    = 0;
         ring_issued[i]   = 0;
         ring_finished[i] = 0;
         tag_written[i]   = 0;
      end
      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_full();
      test_random();
      test_backpressure();
      test_random();
      if (pending_rsps.size() != 0) begin
         $error("%0d results never arrived", pending_rsps.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
